// ===== rtl/wtss_pkg.sv =====
package wtss_pkg;

  // sample format and period
  localparam int SAMPLE_BITS        = 14;
  localparam int SAMPLES_PER_PERIOD = 16384;
  localparam int PER_W              = $clog2(SAMPLES_PER_PERIOD);
  localparam int IDX_W              = 14;
  localparam int FULL_SCALE         = 1 << (SAMPLE_BITS - 1);

  // working widths
  localparam int VAL_W = SAMPLE_BITS + 2;
  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int QUO_W = SAMPLE_BITS;

  // pipeline depths
  localparam int SINE_TERMS = 6;
  localparam int SINE_LAT   = 2 + 3 * SINE_TERMS;
  localparam int CORE_LAT   = 3 + QUO_W;
  localparam int ALIGN_LAT  = SINE_LAT - CORE_LAT;

  // waveform kinds
  localparam logic [2:0] KIND_SINE      = 3'd0;
  localparam logic [2:0] KIND_TRIANGLE  = 3'd1;
  localparam logic [2:0] KIND_SQUARE    = 3'd2;
  localparam logic [2:0] KIND_RAMP_UP   = 3'd3;
  localparam logic [2:0] KIND_RAMP_DOWN = 3'd4;
  localparam logic [2:0] KIND_DC        = 3'd5;
  localparam logic [2:0] KIND_PWM       = 3'd6;

  // register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE = 2'd2;

  typedef struct packed {
    logic [2:0]            kind;
    logic [15:0]           duty;
    logic [CFG_DATA_W-1:0] tone;
  } wtss_cfg_t;

  typedef struct packed {
    logic                    is_sine;
    logic                    neg;
    logic signed [VAL_W-1:0] value;
  } wtss_shape_t;

endpackage

// ===== rtl/wtss_sine.sv =====
module wtss_sine (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [wtss_pkg::PER_W:0]          rr_i,
  output logic [wtss_pkg::MAG_W-1:0]        mag_o
);

  localparam int X_W   = 31;
  localparam int X2_W  = 32;
  localparam int SUM_W = 32;
  localparam int SH    = 30 - (wtss_pkg::SAMPLE_BITS - 1);
  localparam int P1_W  = X_W + wtss_pkg::PER_W + 1;
  localparam logic [X_W-1:0] HALF_PI = 31'd1686629713;

  logic [P1_W-1:0]    prod1;
  logic [X_W-1:0]     x_q;
  logic [2*X_W-1:0]   sq;
  logic [X_W-1:0]     term_q [wtss_pkg::SINE_TERMS+1];
  logic [SUM_W-1:0]   sum_q  [wtss_pkg::SINE_TERMS+1];
  logic [X2_W-1:0]    x2_q   [wtss_pkg::SINE_TERMS+1];
  logic [SUM_W:0]     rnd;

  // angle in q30: pi/2 * rr / n
  assign prod1 = P1_W'(HALF_PI) * P1_W'(rr_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= prod1[wtss_pkg::PER_W +: X_W];
    end
  end

  // square of the angle, seeds the series
  assign sq = (2*X_W)'(x_q) * (2*X_W)'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q[0] <= x_q;
      sum_q[0]  <= SUM_W'(x_q);
      x2_q[0]   <= sq[30 +: X2_W];
    end
  end

  // one series term per three stages: multiply, reciprocal estimate, correct
  for (genvar j = 0; j < wtss_pkg::SINE_TERMS; j++) begin : g_term
    localparam int         K     = 3 + 2 * j;
    localparam logic [7:0] DIV   = 8'(K * (K - 1));
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / (K * (K - 1)));
    localparam bit         SUB   = ((j % 2) == 0);

    logic [X_W+X2_W-1:0] pa_prod;
    logic [31:0]         p_q;
    logic [X2_W-1:0]     xa_q;
    logic [SUM_W-1:0]    sa_q;
    logic [63:0]         eb_prod;
    logic [31:0]         est_q;
    logic [31:0]         pb_q;
    logic [X2_W-1:0]     xb_q;
    logic [SUM_W-1:0]    sb_q;
    logic [39:0]         back;
    logic [39:0]         rem;
    logic [31:0]         quo;

    assign pa_prod = (X_W+X2_W)'(term_q[j]) * (X_W+X2_W)'(x2_q[j]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q  <= pa_prod[30 +: 32];
        xa_q <= x2_q[j];
        sa_q <= sum_q[j];
      end
    end

    assign eb_prod = 64'(p_q) * 64'(RECIP);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        est_q <= eb_prod[63:32];
        pb_q  <= p_q;
        xb_q  <= xa_q;
        sb_q  <= sa_q;
      end
    end

    // estimate is low by at most one
    assign back = 40'(est_q) * 40'(DIV);
    assign rem  = 40'(pb_q) - back;
    assign quo  = est_q + 32'(rem >= 40'(DIV));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        term_q[j+1] <= quo[X_W-1:0];
        x2_q[j+1]   <= xb_q;
        sum_q[j+1]  <= SUB ? (sb_q - quo) : (sb_q + quo);
      end
    end
  end

  // round q30 down to the sample grid
  assign rnd   = (SUM_W+1)'(sum_q[wtss_pkg::SINE_TERMS]) + (SUM_W+1)'(1 << (SH - 1));
  assign mag_o = rnd[SH +: wtss_pkg::MAG_W];

endmodule

// ===== rtl/wtss_shape.sv =====
module wtss_shape (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [wtss_pkg::IDX_W-1:0]      idx_i,
  input  logic [wtss_pkg::PER_W:0]        rr_i,
  input  logic                            neg_i,
  input  wtss_pkg::wtss_cfg_t             cfg_i,
  output wtss_pkg::wtss_shape_t           shape_o
);

  localparam int SB    = wtss_pkg::SAMPLE_BITS;
  localparam int NP    = wtss_pkg::SAMPLES_PER_PERIOD;
  localparam int VW    = wtss_pkg::VAL_W;
  localparam int QW    = wtss_pkg::QUO_W;
  localparam int TW    = wtss_pkg::PER_W + SB;
  localparam int HW    = 16 + wtss_pkg::PER_W - 1;
  localparam int D1_W  = 26;
  localparam int T_W   = 25;
  localparam int W_W   = 15;
  localparam int DW    = 41;
  localparam int DV_W  = T_W + 1;
  localparam int N_W   = D1_W + 2;
  localparam logic signed [VW-1:0] TOP    = VW'(wtss_pkg::FULL_SCALE - 1);
  localparam logic signed [VW-1:0] BOTTOM = -VW'(wtss_pkg::FULL_SCALE);
  localparam logic [31:0] W_RECIP = 32'((64'd1 << 32) / 10000);
  localparam logic [wtss_pkg::IDX_W-1:0] IDX_LAST = wtss_pkg::IDX_W'(NP - 1);

  typedef struct packed {
    logic [DW-1:0]   rem;
    logic [DV_W-1:0] dv;
    logic [QW-1:0]   quo;
    logic            span;
    logic            sneg;
    logic signed [VW-1:0] va;
    logic            is_sine;
    logic            neg;
  } wtss_div_t;

  // ---------------- transition width from the tone frequency
  logic [27:0]    wraw;
  logic [59:0]    west_prod;
  logic [27:0]    wraw_q;
  logic [27:0]    west_q;
  logic [41:0]    wback;
  logic [41:0]    wrem;
  logic [27:0]    wcor;
  logic [W_W-1:0] w_q;

  assign wraw      = 28'(cfg_i.tone) * 28'd3;
  assign west_prod = 60'(wraw) * 60'(W_RECIP);

  always_ff @(posedge clk_i) begin
    wraw_q <= wraw;
    west_q <= west_prod[32 +: 28];
  end

  assign wback = 42'(west_q) * 42'd10000;
  assign wrem  = 42'(wraw_q) - wback;
  assign wcor  = west_q + 28'(wrem >= 42'd10000);

  always_ff @(posedge clk_i) begin
    w_q <= (wcor <= 28'd10) ? W_W'(30) : wcor[W_W-1:0];
  end

  // ---------------- stage a: plain waveforms and span offsets
  logic [24:0]            i1000;
  logic signed [D1_W-1:0] d1;
  logic signed [17:0]     d2;
  logic [TW-1:0]          tri_sum;
  logic [TW-1:0]          ru_sum;
  logic [TW-1:0]          rd_sum;
  logic [SB-1:0]          tri_mag;
  logic [SB-1:0]          ru_mag;
  logic [SB-1:0]          rd_mag;
  logic [HW-1:0]          h_w;
  logic [wtss_pkg::PER_W:0] h;
  logic                   pwm_hi;
  logic                   sq_hi;
  logic signed [VW-1:0]   va;

  logic [2:0]             a_kind_q;
  logic signed [VW-1:0]   a_va_q;
  logic                   a_neg_q;
  logic signed [D1_W-1:0] a_d1_q;
  logic signed [17:0]     a_d2_q;

  always_comb begin
    i1000   = 25'(idx_i) * 25'd1000;
    d1      = $signed({1'b0, i1000}) - D1_W'(249 * NP);
    d2      = $signed({2'b00, idx_i, 2'b00}) - 18'(3 * NP);
    tri_sum = (TW'(rr_i) << (SB - 1)) + TW'(NP / 2);
    ru_sum  = ((TW'(idx_i) + TW'(2)) << (SB - 1)) + TW'(NP / 2);
    rd_sum  = ((TW'(NP) - TW'(idx_i)) << (SB - 1)) + TW'(NP / 2);
    tri_mag = tri_sum[wtss_pkg::PER_W +: SB];
    ru_mag  = ru_sum[wtss_pkg::PER_W +: SB];
    rd_mag  = rd_sum[wtss_pkg::PER_W +: SB];
    h_w     = HW'(cfg_i.duty) << (wtss_pkg::PER_W - 1);
    h       = (wtss_pkg::PER_W+1)'(h_w[HW-1:16]);
    pwm_hi  = ({1'b0, idx_i} < h) ||
              ({1'b0, idx_i} >= ((wtss_pkg::PER_W+1)'(NP) - h));
    sq_hi   = (idx_i != '0) && ({1'b0, idx_i} < (wtss_pkg::PER_W+1)'(NP / 2));
    case (cfg_i.kind)
      wtss_pkg::KIND_SINE:      va = '0;
      wtss_pkg::KIND_TRIANGLE:  va = neg_i ? -$signed({2'b00, tri_mag})
                                           : $signed({2'b00, tri_mag});
      wtss_pkg::KIND_SQUARE:    va = sq_hi ? TOP : BOTTOM;
      wtss_pkg::KIND_RAMP_UP:   va = (idx_i == IDX_LAST) ? '0 : $signed({2'b00, ru_mag});
      wtss_pkg::KIND_RAMP_DOWN: va = $signed({2'b00, rd_mag});
      wtss_pkg::KIND_DC:        va = TOP;
      wtss_pkg::KIND_PWM:       va = pwm_hi ? TOP : BOTTOM;
      default:                  va = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_kind_q <= cfg_i.kind;
      a_va_q   <= va;
      a_neg_q  <= neg_i;
      a_d1_q   <= d1;
      a_d2_q   <= d2;
    end
  end

  // ---------------- stage b: pick transition span, set up the division
  logic [T_W-1:0]         t1;
  logic [T_W-1:0]         t2;
  logic signed [D1_W-1:0] d2x;
  logic                   act1;
  logic                   act2;
  logic signed [D1_W-1:0] dsel;
  logic [T_W-1:0]         tsel;
  logic signed [N_W-1:0]  num;
  logic [N_W-1:0]         anum;
  wtss_div_t              dv_q [QW+1];

  always_comb begin
    t1   = T_W'(w_q) * T_W'(1000);
    t2   = T_W'(w_q) * T_W'(4);
    d2x  = D1_W'(a_d2_q);
    act1 = (a_d1_q > 0) && (a_d1_q <= $signed({1'b0, t1}));
    act2 = (d2x > 0) && (d2x <= $signed({1'b0, t2}));
    dsel = act2 ? d2x : a_d1_q;
    tsel = act2 ? t2 : t1;
    num  = (N_W'(dsel) <<< 1) - $signed(N_W'(tsel));
    anum = num[N_W-1] ? N_W'(-num) : N_W'(num);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0].rem     <= (DW'(anum[T_W-1:0]) << SB) + DW'(tsel);
      dv_q[0].dv      <= {tsel, 1'b0};
      dv_q[0].quo     <= '0;
      dv_q[0].span    <= (a_kind_q == wtss_pkg::KIND_SQUARE) && (act1 || act2);
      dv_q[0].sneg    <= num[N_W-1] ^ !act2;
      dv_q[0].va      <= a_va_q;
      dv_q[0].is_sine <= (a_kind_q == wtss_pkg::KIND_SINE);
      dv_q[0].neg     <= a_neg_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int BIT = QW - 1 - s;
    logic [DW-1:0] trial;
    wtss_div_t     nxt;

    always_comb begin
      trial = DW'(dv_q[s].dv) << BIT;
      nxt   = dv_q[s];
      if (dv_q[s].rem >= trial) begin
        nxt.rem      = dv_q[s].rem - trial;
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[s+1] <= nxt;
      end
    end
  end

  // ---------------- finish and align with the sine path
  wtss_pkg::wtss_shape_t fin;
  logic signed [VW-1:0]  qv;
  wtss_pkg::wtss_shape_t al_q [wtss_pkg::ALIGN_LAT+1];

  always_comb begin
    qv          = $signed({{(VW-QW){1'b0}}, dv_q[QW].quo});
    fin.is_sine = dv_q[QW].is_sine;
    fin.neg     = dv_q[QW].neg;
    fin.value   = dv_q[QW].span ? (dv_q[QW].sneg ? -qv : qv) : dv_q[QW].va;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      al_q[0] <= fin;
    end
  end

  for (genvar k = 0; k < wtss_pkg::ALIGN_LAT; k++) begin : g_align
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        al_q[k+1] <= al_q[k];
      end
    end
  end

  assign shape_o = al_q[wtss_pkg::ALIGN_LAT];

endmodule

// ===== rtl/waveform_table_sample_synthesizer.sv =====
// Waveform sample synthesizer: each beat on the input stream carries a sample index within
// one 16384-sample period, and the block answers with that sample of the waveform chosen in
// register 0 (sine, triangle, square, ramp up, ramp down, dc, pwm; code 7 gives zero) as a
// signed Q1.13 value, +1.0 saturating to 8191. Register 1 holds the pwm duty (Q0.16) and
// register 2 the tone frequency in hertz, which sets the square-wave edge width. Write
// registers only while no beat is in flight. One sample is accepted every clock cycle while
// the output is not stalled; a result beat passes the input register, then 20 stages set by
// the sine series (two stages for the angle and its square, three stages for each of six
// terms) with the square-edge divider running alongside, then the output register. A result
// held on the output stalls the whole pipeline and the input with it.
module waveform_table_sample_synthesizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: [13:0] sample_index
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [15:0]                          s_axis_tdata,
  // tdata: [13:0] sample_value
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wtss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wtss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SB  = wtss_pkg::SAMPLE_BITS;
  localparam int VW  = wtss_pkg::VAL_W;
  localparam int LAT = wtss_pkg::SINE_LAT;
  localparam logic signed [VW-1:0] TOP    = VW'(wtss_pkg::FULL_SCALE - 1);
  localparam logic signed [VW-1:0] BOTTOM = -VW'(wtss_pkg::FULL_SCALE);

  logic                          en;
  logic [LAT:0]                  vld_q;
  logic [wtss_pkg::IDX_W-1:0]    idx_q;
  logic [wtss_pkg::IDX_W+1:0]    p;
  logic [wtss_pkg::PER_W:0]      rr;
  logic                          neg;
  wtss_pkg::wtss_cfg_t           cfg_q;
  logic [wtss_pkg::MAG_W-1:0]    sine_mag;
  wtss_pkg::wtss_shape_t         shape;
  logic signed [VW-1:0]          smag;
  logic signed [VW-1:0]          full;
  logic [SB-1:0]                 out_d;
  logic                          out_vld_q;
  logic [SB-1:0]                 out_q;

  // whole pipeline moves when the output register is empty or its result is being taken
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind <= wtss_pkg::KIND_SINE;
      cfg_q.duty <= 16'd32768;
      cfg_q.tone <= wtss_pkg::CFG_DATA_W'(1000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wtss_pkg::CFG_KIND: cfg_q.kind <= cfg_data_i[2:0];
        wtss_pkg::CFG_DUTY: cfg_q.duty <= cfg_data_i[15:0];
        wtss_pkg::CFG_TONE: cfg_q.tone <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT-1:0], s_axis_tvalid};
      out_vld_q <= vld_q[LAT];
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= s_axis_tdata[wtss_pkg::IDX_W-1:0];
    end
  end

  // quadrant fold: odd quadrants mirror, upper half negates
  assign p   = {idx_q, 2'b00};
  assign neg = p[wtss_pkg::PER_W+1];
  assign rr  = p[wtss_pkg::PER_W]
             ? (wtss_pkg::PER_W+1)'(wtss_pkg::SAMPLES_PER_PERIOD)
               - {1'b0, p[wtss_pkg::PER_W-1:0]}
             : {1'b0, p[wtss_pkg::PER_W-1:0]};

  wtss_sine u_sine (
    .clk_i (clk_i),
    .en_i  (en),
    .rr_i  (rr),
    .mag_o (sine_mag)
  );

  wtss_shape u_shape (
    .clk_i   (clk_i),
    .en_i    (en),
    .idx_i   (idx_q),
    .rr_i    (rr),
    .neg_i   (neg),
    .cfg_i   (cfg_q),
    .shape_o (shape)
  );

  // merge sine, saturate
  always_comb begin
    smag = $signed({1'b0, sine_mag});
    full = shape.is_sine ? (shape.neg ? -smag : smag) : shape.value;
    if (full > TOP) begin
      out_d = TOP[SB-1:0];
    end else if (full < BOTTOM) begin
      out_d = BOTTOM[SB-1:0];
    end else begin
      out_d = full[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16-SB){1'b0}}, out_q};

`ifndef SYNTH
  // a held result must stop the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // a result appears only from the last pipeline stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[LAT]))
    else $error("output valid without a pipeline item");

  // sine series stays near full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT] && shape.is_sine) |->
      (sine_mag <= wtss_pkg::MAG_W'(wtss_pkg::FULL_SCALE + 1)))
    else $error("sine magnitude out of range");
`endif

endmodule
